/* rtl/core/rra_pkg.sv */
// rra_pkg: shared types and codes of the rectangle region allocator.
// Holds the rectangle record, operation and status codes; no dependencies.
package rra_pkg;

    localparam int COORD_W = 13;

    typedef logic [COORD_W-1:0] coord_t;

    // x sits in the lowest bits so the record packs straight into tdata.
    typedef struct packed {
        coord_t h;
        coord_t w;
        coord_t y;
        coord_t x;
    } box_t;

    localparam int BOX_W  = $bits(box_t);
    localparam int DATA_W = ((BOX_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_ATLAS  = 3'd4
    } status_t;

    localparam int STATUS_W = $bits(status_t);

endpackage

/* rtl/core/rect_region_allocator.sv */
// rect_region_allocator: guillotine rectangle allocator for an atlas.
// Depends on rra_pkg; holds the free and used tables as on-chip memories.

// One request word in, one result word out. A clear (op 2) is settled in
// the dispatch state and goes straight to the response. An allocate walks
// the free table, one read and one check per entry, until an exact or
// one-side fit is found, then may compact the table, moving entries down,
// and append up to two pieces. A free walks the used table, shifts the
// free table up by one, then merges: each merge rescans the free table and
// compacts it. Each table memory has a single read port, which delivers
// one entry per cycle with registered read data. The next request word is
// accepted as soon as a result is loaded into the output register, even
// while that result still waits for m_tready. op travels in s_tuser, the
// status in m_tuser; on any status other than ok the result rectangle is
// zero. Both tables come out of reset empty (counts zero) and need no
// clearing pass.
module rect_region_allocator
    import rra_pkg::*;
#(
    parameter int MAX_SIDE   = 4096,
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata fields, lowest bit up: rect_x, rect_y, rect_w, rect_h, zero pad
    input  logic [DATA_W-1:0]   s_tdata,
    // s_tuser fields: op
    input  logic [1:0]          s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata fields, lowest bit up: out_x, out_y, out_w, out_h, zero pad
    output logic [DATA_W-1:0]   m_tdata,
    // m_tuser fields: status
    output logic [STATUS_W-1:0] m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready
);

    localparam int FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int UIW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int UCW = $clog2(USED_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_A_RD, S_A_EV, S_A_DECIDE, S_A_APP1, S_A_APP2,
        S_A_USED, S_FD_RD, S_FD_WR, S_F_RD, S_F_EV, S_FU_RD, S_FU_WR, S_F_INS,
        S_C_RD, S_C_EV, S_C_RST, S_UD_RD, S_UD_WR, S_RESP
    } state_t;

    // How the chosen free entry fits the request.
    typedef enum logic [1:0] {
        FIT_SPLIT  = 2'd0,
        FIT_EXACT  = 2'd1,
        FIT_WIDTH  = 2'd2,
        FIT_HEIGHT = 2'd3
    } fit_t;

    // Table memories, read data registered.
    box_t fmem [FREE_SLOTS];
    box_t umem [USED_SLOTS];
    box_t f_rd_reg, u_rd_reg;

    logic           f_we, u_we;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [UIW-1:0] u_waddr, u_raddr;
    box_t           f_wdata, u_wdata;

    state_t         state_reg, ret_reg;
    op_t            op_reg;
    box_t           req_reg;
    coord_t         atlas_w_reg, atlas_h_reg;
    logic [FCW-1:0] fcnt_reg, fi_reg, fj_reg, t_reg, tn_reg, at_reg, bi_reg;
    logic [UCW-1:0] ucnt_reg, ui_reg, uj_reg, k_reg;
    fit_t           kind_reg;
    logic           have_reg;
    box_t           cur_reg, best_reg, g_reg, res_reg;
    status_t        st_reg;
    logic           m_valid_reg;
    status_t        m_st_reg;
    box_t           m_box_reg;

    // Clear sizes, saturated to the largest side.
    coord_t clr_w, clr_h;
    always_comb begin
        clr_w = req_reg.w;
        clr_h = req_reg.h;
        if (32'(req_reg.w) > MAX_SIDE) clr_w = COORD_W'(MAX_SIDE);
        if (32'(req_reg.h) > MAX_SIDE) clr_h = COORD_W'(MAX_SIDE);
    end

    // Pieces of a guillotine split of the best entry, and the leftover of a one-side fit.
    box_t g_split, ru_box, dn_box, k2_box, k3_box;
    always_comb begin
        g_split = '{x: best_reg.x, y: best_reg.y, w: req_reg.w, h: req_reg.h};
        ru_box  = '{x: best_reg.x + req_reg.w, y: best_reg.y,
                    w: best_reg.w - req_reg.w, h: req_reg.h};
        dn_box  = '{x: best_reg.x, y: best_reg.y + req_reg.h,
                    w: best_reg.w, h: best_reg.h - req_reg.h};
        k2_box  = '{x: cur_reg.x, y: cur_reg.y + req_reg.h,
                    w: cur_reg.w, h: cur_reg.h - req_reg.h};
        k3_box  = '{x: cur_reg.x + req_reg.w, y: cur_reg.y,
                    w: cur_reg.w - req_reg.w, h: cur_reg.h};
    end

    // Edge match of a candidate against the rectangle being merged.
    logic [COORD_W:0] cl, cr, ct, cb, gl, gr, gt, gb;
    logic             join_v, join_h, joined;
    box_t             merged;
    always_comb begin
        cl = {1'b0, f_rd_reg.x};
        cr = {1'b0, f_rd_reg.x} + {1'b0, f_rd_reg.w};
        ct = {1'b0, f_rd_reg.y};
        cb = {1'b0, f_rd_reg.y} + {1'b0, f_rd_reg.h};
        gl = {1'b0, g_reg.x};
        gr = {1'b0, g_reg.x} + {1'b0, g_reg.w};
        gt = {1'b0, g_reg.y};
        gb = {1'b0, g_reg.y} + {1'b0, g_reg.h};
        join_v = (cl == gl) && (cr == gr) && ((ct == gb) || (cb == gt));
        join_h = !join_v && (ct == gt) && (cb == gb) && ((cl == gr) || (cr == gl));
        joined = join_v || join_h;
        merged = f_rd_reg;
        if (join_v) begin
            if (ct == gb) merged.y = g_reg.y;
            merged.h = f_rd_reg.h + g_reg.h;
        end else if (join_h) begin
            if (cl == gr) merged.x = g_reg.x;
            merged.w = f_rd_reg.w + g_reg.w;
        end
    end

    // Memory port control.
    always_comb begin
        f_we    = 1'b0;
        f_waddr = fj_reg[FIW-1:0];
        f_wdata = f_rd_reg;
        f_raddr = fi_reg[FIW-1:0];
        u_we    = 1'b0;
        u_waddr = uj_reg[UIW-1:0];
        u_wdata = u_rd_reg;
        u_raddr = ui_reg[UIW-1:0];
        case (state_reg)
            S_DISPATCH: begin
                f_we    = (op_reg == OP_CLEAR);
                f_waddr = '0;
                f_wdata = '{x: '0, y: '0, w: clr_w, h: clr_h};
            end
            S_A_DECIDE: begin
                f_waddr = at_reg[FIW-1:0];
                f_wdata = (kind_reg == FIT_WIDTH) ? k2_box : k3_box;
                f_we    = (kind_reg == FIT_WIDTH || kind_reg == FIT_HEIGHT) &&
                          (ucnt_reg < UCW'(USED_SLOTS));
            end
            S_A_APP1, S_A_APP2: begin
                f_we    = 1'b1;
                f_waddr = fcnt_reg[FIW-1:0];
                f_wdata = (state_reg == S_A_APP1) ? ru_box : dn_box;
            end
            S_A_USED: begin
                u_we    = 1'b1;
                u_waddr = ucnt_reg[UIW-1:0];
                u_wdata = g_reg;
            end
            S_FD_RD:  f_raddr = FIW'(fj_reg + 1'b1);
            S_FD_WR:  f_we = 1'b1;
            S_FU_RD:  f_raddr = FIW'(fj_reg - 1'b1);
            S_FU_WR:  f_we = 1'b1;
            S_F_INS: begin
                f_we    = 1'b1;
                f_waddr = '0;
                f_wdata = req_reg;
            end
            S_C_EV: begin
                f_we    = joined;
                f_waddr = fi_reg[FIW-1:0];
                f_wdata = merged;
            end
            S_UD_RD:  u_raddr = UIW'(uj_reg + 1'b1);
            S_UD_WR:  u_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (f_we) fmem[f_waddr] <= f_wdata;
        if (u_we) umem[u_waddr] <= u_wdata;
        f_rd_reg <= fmem[f_raddr];
        u_rd_reg <= umem[u_raddr];
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            atlas_w_reg <= '0;
            atlas_h_reg <= '0;
            fcnt_reg    <= '0;
            ucnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop a taken result word; the response state loads its own.
            if (m_valid_reg && m_tready && state_reg != S_RESP) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        req_reg   <= box_t'(s_tdata[BOX_W-1:0]);
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    res_reg   <= '0;
                    st_reg    <= ST_OK;
                    state_reg <= S_RESP;
                    unique case (op_reg)
                        OP_CLEAR: begin
                            ucnt_reg <= '0;
                            if (clr_w == '0 || clr_h == '0) begin
                                fcnt_reg    <= '0;
                                atlas_w_reg <= '0;
                                atlas_h_reg <= '0;
                                st_reg      <= ST_NO_ATLAS;
                            end else begin
                                fcnt_reg    <= FCW'(1);
                                atlas_w_reg <= clr_w;
                                atlas_h_reg <= clr_h;
                                res_reg     <= '{x: '0, y: '0, w: clr_w, h: clr_h};
                            end
                        end
                        OP_ALLOC: begin
                            if (atlas_w_reg == '0 || atlas_h_reg == '0) begin
                                st_reg <= ST_NO_ATLAS;
                            end else if (req_reg.w == '0 || req_reg.h == '0) begin
                                st_reg <= ST_NO_FIT;
                            end else begin
                                fi_reg    <= '0;
                                kind_reg  <= FIT_SPLIT;
                                have_reg  <= 1'b0;
                                state_reg <= S_A_RD;
                            end
                        end
                        OP_FREE: begin
                            ui_reg    <= '0;
                            state_reg <= S_F_RD;
                        end
                        default: ;
                    endcase
                end
                // Walk the free table in order.
                S_A_RD: state_reg <= (fi_reg == fcnt_reg) ? S_A_DECIDE : S_A_EV;
                S_A_EV: begin
                    state_reg <= S_A_RD;
                    fi_reg    <= fi_reg + 1'b1;
                    if (f_rd_reg.w == req_reg.w && f_rd_reg.h == req_reg.h) begin
                        kind_reg <= FIT_EXACT;
                    end else if (f_rd_reg.w == req_reg.w && f_rd_reg.h >= req_reg.h) begin
                        kind_reg <= FIT_WIDTH;
                    end else if (f_rd_reg.w >= req_reg.w && f_rd_reg.h == req_reg.h) begin
                        kind_reg <= FIT_HEIGHT;
                    end else if (f_rd_reg.w >= req_reg.w && f_rd_reg.h >= req_reg.h &&
                                 (!have_reg || (f_rd_reg.w <= best_reg.w &&
                                                f_rd_reg.h <= best_reg.h))) begin
                        have_reg <= 1'b1;
                        best_reg <= f_rd_reg;
                        bi_reg   <= fi_reg;
                    end
                    // Stop at the first exact or one-side fit.
                    if ((f_rd_reg.w == req_reg.w && f_rd_reg.h >= req_reg.h) ||
                        (f_rd_reg.w >= req_reg.w && f_rd_reg.h == req_reg.h)) begin
                        at_reg    <= fi_reg;
                        cur_reg   <= f_rd_reg;
                        state_reg <= S_A_DECIDE;
                    end
                end
                S_A_DECIDE: begin
                    state_reg <= S_A_USED;
                    if (kind_reg == FIT_SPLIT && !have_reg) begin
                        st_reg    <= ST_NO_FIT;
                        res_reg   <= '0;
                        state_reg <= S_RESP;
                    end else if (ucnt_reg >= UCW'(USED_SLOTS) ||
                                 (kind_reg == FIT_SPLIT && fcnt_reg >= FCW'(FREE_SLOTS))) begin
                        st_reg    <= ST_FULL;
                        res_reg   <= '0;
                        state_reg <= S_RESP;
                    end else begin
                        case (kind_reg)
                            FIT_EXACT: begin
                                g_reg     <= cur_reg;
                                fj_reg    <= at_reg;
                                ret_reg   <= S_A_USED;
                                state_reg <= S_FD_RD;
                            end
                            FIT_WIDTH: g_reg <= '{x: cur_reg.x, y: cur_reg.y,
                                                  w: cur_reg.w, h: req_reg.h};
                            FIT_HEIGHT: g_reg <= '{x: cur_reg.x, y: cur_reg.y,
                                                   w: req_reg.w, h: cur_reg.h};
                            default: begin
                                g_reg     <= g_split;
                                fj_reg    <= bi_reg;
                                ret_reg   <= S_A_APP1;
                                state_reg <= S_FD_RD;
                            end
                        endcase
                    end
                end
                S_A_APP1: begin
                    fcnt_reg  <= fcnt_reg + 1'b1;
                    state_reg <= S_A_APP2;
                end
                S_A_APP2: begin
                    fcnt_reg  <= fcnt_reg + 1'b1;
                    state_reg <= S_A_USED;
                end
                S_A_USED: begin
                    ucnt_reg  <= ucnt_reg + 1'b1;
                    res_reg   <= g_reg;
                    st_reg    <= ST_OK;
                    state_reg <= S_RESP;
                end
                // Remove free entry fj: pull the tail down by one.
                S_FD_RD: begin
                    if (FCW'(fj_reg + 1'b1) < fcnt_reg) begin
                        state_reg <= S_FD_WR;
                    end else begin
                        fcnt_reg  <= fcnt_reg - 1'b1;
                        state_reg <= ret_reg;
                    end
                end
                S_FD_WR: begin
                    fj_reg    <= fj_reg + 1'b1;
                    state_reg <= S_FD_RD;
                end
                // Look up the rectangle in the used table.
                S_F_RD: begin
                    if (ui_reg == ucnt_reg) begin
                        st_reg    <= ST_NOT_ALLOC;
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_F_EV;
                    end
                end
                S_F_EV: begin
                    if (u_rd_reg == req_reg) begin
                        if (fcnt_reg >= FCW'(FREE_SLOTS)) begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_RESP;
                        end else begin
                            k_reg     <= ui_reg;
                            fj_reg    <= fcnt_reg;
                            state_reg <= S_FU_RD;
                        end
                    end else begin
                        ui_reg    <= ui_reg + 1'b1;
                        state_reg <= S_F_RD;
                    end
                end
                // Open slot 0: push the free table up by one.
                S_FU_RD: state_reg <= (fj_reg == '0) ? S_F_INS : S_FU_WR;
                S_FU_WR: begin
                    fj_reg    <= fj_reg - 1'b1;
                    state_reg <= S_FU_RD;
                end
                S_F_INS: begin
                    fcnt_reg  <= fcnt_reg + 1'b1;
                    t_reg     <= '0;
                    g_reg     <= req_reg;
                    fi_reg    <= '0;
                    state_reg <= S_C_RD;
                end
                // Merge pass: scan for a neighbor sharing a full edge.
                S_C_RD: begin
                    if (fi_reg == fcnt_reg) begin
                        uj_reg    <= k_reg;
                        state_reg <= S_UD_RD;
                    end else if (fi_reg == t_reg) begin
                        fi_reg <= fi_reg + 1'b1;
                    end else begin
                        state_reg <= S_C_EV;
                    end
                end
                S_C_EV: begin
                    if (joined) begin
                        g_reg     <= merged;
                        tn_reg    <= (fi_reg > t_reg) ? fi_reg - 1'b1 : fi_reg;
                        fj_reg    <= t_reg;
                        ret_reg   <= S_C_RST;
                        state_reg <= S_FD_RD;
                    end else begin
                        fi_reg    <= fi_reg + 1'b1;
                        state_reg <= S_C_RD;
                    end
                end
                S_C_RST: begin
                    t_reg     <= tn_reg;
                    fi_reg    <= '0;
                    state_reg <= S_C_RD;
                end
                // Drop the used entry k.
                S_UD_RD: begin
                    if (UCW'(uj_reg + 1'b1) < ucnt_reg) begin
                        state_reg <= S_UD_WR;
                    end else begin
                        ucnt_reg  <= ucnt_reg - 1'b1;
                        st_reg    <= ST_OK;
                        res_reg   <= req_reg;
                        state_reg <= S_RESP;
                    end
                end
                S_UD_WR: begin
                    uj_reg    <= uj_reg + 1'b1;
                    state_reg <= S_UD_RD;
                end
                // Hold until the output register is free, then load it.
                S_RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_st_reg    <= st_reg;
                        m_box_reg   <= (st_reg == ST_OK) ? res_reg : '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_st_reg;
    assign m_tdata  = {{(DATA_W - BOX_W){1'b0}}, m_box_reg};

endmodule

/* rtl/core/rra_checker.sv */
// rra_checker: port-level assertions for rect_region_allocator.
// Depends on rra_pkg; attached to rect_region_allocator by the bind below.
module rra_checker
    import rra_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic [DATA_W-1:0]   s_tdata,
    input logic [1:0]          s_tuser,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [DATA_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tvalid,
    input logic                m_tready
);

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A failed request carries a zero rectangle.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero rectangle on failure");

    // Status codes stay in range.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_NO_ATLAS)
        else $error("status code out of range");

    // One request at a time: a taken word closes the input.
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an accepted word");

endmodule

bind rect_region_allocator rra_checker u_rra_checker (.*);
